/* rtl/hfm_pkg.sv */
// ----------------------------------------------------------------------------
// hfm_pkg
// Shared types and constants of the magnetometer heading unit: datapath
// widths, angle constants, the CORDIC arctangent table and the command
// bundle between controller and datapath.
// ----------------------------------------------------------------------------
package hfm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int HEADING_W = 15;
    // Working width: 2^23 input magnitude times CORDIC gain plus sign fits in 27 bits.
    localparam int DW        = 27;
    localparam int PRESCALE_SH = 8;
    localparam int ACC_FRAC  = 16;
    localparam int HALF_TURN = 180;
    localparam int TABLE_LEN = 24;
    localparam int IDX_W     = 5;
    localparam int ATAN_W    = 22;

    localparam logic signed [DW-1:0] HALF_Q16 = DW'(HALF_TURN << ACC_FRAC);
    localparam logic signed [DW-1:0] FULL_Q16 = DW'((2 * HALF_TURN) << ACC_FRAC);

    typedef struct packed {
        logic             load;      // capture sample, fold left half-plane
        logic             step;      // one CORDIC vectoring iteration
        logic [IDX_W-1:0] step_idx;  // iteration number / shift amount
        logic             finish;    // offset, clamp, round into heading register
    } hfm_cmd_t;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = ATAN_W'(2949120);
            5'd1:    v = ATAN_W'(1740967);
            5'd2:    v = ATAN_W'(919879);
            5'd3:    v = ATAN_W'(466945);
            5'd4:    v = ATAN_W'(234379);
            5'd5:    v = ATAN_W'(117304);
            5'd6:    v = ATAN_W'(58666);
            5'd7:    v = ATAN_W'(29335);
            5'd8:    v = ATAN_W'(14668);
            5'd9:    v = ATAN_W'(7334);
            5'd10:   v = ATAN_W'(3667);
            5'd11:   v = ATAN_W'(1833);
            5'd12:   v = ATAN_W'(917);
            5'd13:   v = ATAN_W'(458);
            5'd14:   v = ATAN_W'(229);
            5'd15:   v = ATAN_W'(115);
            5'd16:   v = ATAN_W'(57);
            5'd17:   v = ATAN_W'(29);
            5'd18:   v = ATAN_W'(14);
            5'd19:   v = ATAN_W'(7);
            5'd20:   v = ATAN_W'(4);
            5'd21:   v = ATAN_W'(2);
            5'd22:   v = ATAN_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/hfm_ctrl.sv */
// ----------------------------------------------------------------------------
// hfm_ctrl
// Sequencer of the heading unit: accepts a transaction, runs the CORDIC
// iteration count, triggers the final rounding and raises the done strobe.
// ----------------------------------------------------------------------------
module hfm_ctrl
    import hfm_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output hfm_cmd_t cmd
);

    localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int CW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
    localparam logic [CW-1:0] LAST = CW'(NSTEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.finish   = 1'b0;
        cmd.step_idx = IDX_W'(cnt_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // strobe comes only in the cycle after the rounding step
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FIN))
        else $error("done without a finish step");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && cnt_reg == '0))
        else $error("accepted transaction did not start iterations");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (cnt_reg <= LAST))
        else $error("iteration counter past last step");

endmodule

/* rtl/hfm_dp.sv */
// ----------------------------------------------------------------------------
// hfm_dp
// Datapath of the heading unit: half-plane fold, shared CORDIC vectoring
// iteration (one per cycle), angle offset, clamp and rounding.
// ----------------------------------------------------------------------------
module hfm_dp
    import hfm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 6
)
(
    input  logic                       clk,
    input  hfm_cmd_t                   cmd,
    input  logic signed [SAMPLE_W-1:0] mag_x,
    input  logic signed [SAMPLE_W-1:0] mag_y,
    output logic        [HEADING_W-1:0] heading
);

    localparam int RSH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic [DW-1:0] RND = DW'(1) << (RSH - 1);
    localparam logic [HEADING_W-1:0] ZERO_HEADING =
        HEADING_W'(HALF_TURN << ANGLE_FRAC_BITS);

    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    logic signed [DW-1:0] z_reg, z_next;
    logic                 zero_reg, zero_next;
    logic [HEADING_W-1:0] heading_reg, heading_next;

    logic signed [DW-1:0] xin, yin;
    logic signed [DW-1:0] xs, ys, atan_v;
    logic signed [DW-1:0] total, clamped;
    logic        [DW-1:0] rounded;

    always_comb
    begin
        xin = DW'(mag_x);
        yin = DW'(mag_y);
        xs  = x_reg >>> cmd.step_idx;
        ys  = y_reg >>> cmd.step_idx;
        atan_v = DW'(atan_lut(cmd.step_idx));

        total = z_reg + HALF_Q16;
        if (total[DW-1])
            clamped = '0;
        else if (total > FULL_Q16)
            clamped = FULL_Q16;
        else
            clamped = total;
        rounded = (DW'(clamped) + RND) >> RSH;

        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        zero_next    = zero_reg;
        heading_next = heading_reg;

        if (cmd.load)
        begin
            zero_next = (mag_x == '0) && (mag_y == '0);
            if (mag_x[SAMPLE_W-1])
            begin
                // left half-plane: rotate by half a turn
                x_next = (-xin) <<< PRESCALE_SH;
                y_next = (-yin) <<< PRESCALE_SH;
                z_next = mag_y[SAMPLE_W-1] ? -HALF_Q16 : HALF_Q16;
            end
            else
            begin
                x_next = xin <<< PRESCALE_SH;
                y_next = yin <<< PRESCALE_SH;
                z_next = '0;
            end
        end
        else if (cmd.step)
        begin
            if (!y_reg[DW-1])
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_v;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_v;
            end
        end

        if (cmd.finish)
            heading_next = zero_reg ? ZERO_HEADING : rounded[HEADING_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        zero_reg    <= zero_next;
        heading_reg <= heading_next;
    end

    assign heading = heading_reg;

endmodule

/* rtl/heading_from_magnetometer_xy_unit.sv */
// ----------------------------------------------------------------------------
// heading_from_magnetometer_xy_unit
// Compass heading from one X/Y magnetometer sample: atan2(y,x) in degrees
// plus 180, unsigned, 1/2^ANGLE_FRAC_BITS degree, by CORDIC vectoring.
// ----------------------------------------------------------------------------
//  channel   direction  ports                  transaction at
//  request   in         start, mag_x, mag_y    rising edge with start && !busy
//  result    out        done, heading          rising edge ending the done cycle
//
//  A sample is accepted with a load cycle, then runs the CORDIC iterations
//  of the shared shift-add unit and a rounding cycle before done. busy is
//  low again in the done cycle, so the next sample can be accepted then.
//  heading holds until the next result.
//  Reset clears the sequencer only; no result is pending after reset.
//  The receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module heading_from_magnetometer_xy_unit
    import hfm_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 6
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [SAMPLE_W-1:0]  mag_x,
    input  logic signed [SAMPLE_W-1:0]  mag_y,
    output logic                        done,
    output logic        [HEADING_W-1:0] heading
);

    hfm_cmd_t cmd;

    hfm_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    hfm_dp #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .mag_x   (mag_x),
        .mag_y   (mag_y),
        .heading (heading)
    );

endmodule

/* tb/heading_checker.sv */
// ----------------------------------------------------------------------------
// heading_checker
// Watches the sample and heading channels of the magnetometer heading unit.
// Predicts each heading with a CORDIC vectoring model, queues the predictions
// in order and compares every heading strobe with the oldest one.
// ----------------------------------------------------------------------------
module heading_checker
    import hfm_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 6
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic signed [SAMPLE_W-1:0]  mag_x,
    input  logic signed [SAMPLE_W-1:0]  mag_y,
    input  logic                        done,
    input  logic        [HEADING_W-1:0] heading,
    output int                          mismatches,
    output int                          in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    // atan(2^-i) in degrees, 16 fraction bits
    longint atan_q16 [TABLE_LEN];

    logic [HEADING_W-1:0] expected_headings [$];
    logic [HEADING_W-1:0] want;

    initial
    begin
        atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                     14668, 7334, 3667, 1833, 917, 458, 229, 115,
                     57, 29, 14, 7, 4, 2, 1, 0};
        mismatches = 0;
        in_flight  = 0;
    end

    function automatic logic [HEADING_W-1:0] cordic_heading(
        input logic signed [SAMPLE_W-1:0] sx,
        input logic signed [SAMPLE_W-1:0] sy
    );
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint half;
        longint total;
        longint unsigned rounded;
        half = longint'(HALF_TURN) <<< ACC_FRAC;
        x = sx;
        y = sy;
        z = 0;
        if (x == 0 && y == 0)
            return HEADING_W'(HALF_TURN << ANGLE_FRAC_BITS);
        // fold the left half-plane onto the right one
        if (x < 0)
        begin
            z = (y >= 0) ? half : -half;
            x = -x;
            y = -y;
        end
        x = x * (longint'(1) << PRESCALE_SH);
        y = y * (longint'(1) << PRESCALE_SH);
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q16[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q16[i];
            end
        end
        // CORDIC residual can push past either end of the range
        total = z + half;
        if (total < 0)
            total = 0;
        if (total > 2 * half)
            total = 2 * half;
        rounded = (longint'(total) + (longint'(1) << (ACC_FRAC - ANGLE_FRAC_BITS - 1)))
                  >> (ACC_FRAC - ANGLE_FRAC_BITS);
        return HEADING_W'(rounded);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_headings.size() == 0)
                begin
                    $display("%0t: heading %0d with no transaction pending", $time, heading);
                    mismatches++;
                end
                else
                begin
                    want = expected_headings.pop_front();
                    if (heading !== want)
                    begin
                        $display("%0t: heading mismatch: expected %0d, actual %0d",
                                 $time, want, heading);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                expected_headings.push_back(cordic_heading(mag_x, mag_y));
            in_flight = expected_headings.size();
        end
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Regression for the magnetometer heading unit. Drives directed corner
// samples, then about 1500 random samples shaped toward axes, diagonals,
// the negative X axis and small vectors, with random gaps and burst
// stretches. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
    import hfm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS       = 16;
    localparam int FRAC_BITS   = 6;
    localparam int LATENCY     = STEPS + 2;
    localparam int STALL_LIMIT = 40 * LATENCY;
    localparam int RANDOM_ITEMS = 1500;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [SAMPLE_W-1:0]  mag_x;
    logic signed [SAMPLE_W-1:0]  mag_y;
    logic                        done;
    logic        [HEADING_W-1:0] heading;
    int                          mismatches;
    int                          in_flight;
    bit                          burst;

    heading_from_magnetometer_xy_unit #(
        .CORDIC_STEPS    (STEPS),
        .ANGLE_FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .mag_x   (mag_x),
        .mag_y   (mag_y),
        .done    (done),
        .heading (heading)
    );

    heading_checker #(
        .CORDIC_STEPS    (STEPS),
        .ANGLE_FRAC_BITS (FRAC_BITS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mag_x      (mag_x),
        .mag_y      (mag_y),
        .done       (done),
        .heading    (heading),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // no-progress watchdog: neither a sample nor a heading accepted
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("heading_from_magnetometer_xy_unit regression: fail");
                $finish;
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] corner_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 6))
            0:       v = 16'sh8000;
            1:       v = 16'sh8001;
            2:       v = -16'sd1;
            3:       v = 16'sd0;
            4:       v = 16'sd1;
            5:       v = 16'sh7FFE;
            default: v = 16'sh7FFF;
        endcase
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_sample(
        input logic signed [SAMPLE_W-1:0] x,
        input logic signed [SAMPLE_W-1:0] y
    );
        int gap;
        bit settle;
        gap    = burst ? 0 : $urandom_range(0, 10);
        settle = !burst && ($urandom_range(0, 1) == 1);
        if (gap != 0 || (settle && busy))
        begin
            start <= 1'b0;
            if (settle)
                while (busy)
                    @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        mag_x <= x;
        mag_y <= y;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] sx;
        logic signed [SAMPLE_W-1:0] sy;
        rst_n = 1'b0;
        start = 1'b0;
        mag_x = '0;
        mag_y = '0;
        burst = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: origin, axes, diagonals, full-scale, negative X axis
        drive_sample(16'sd0, 16'sd0);
        drive_sample(16'sh7FFF, 16'sd0);
        drive_sample(16'sh8000, 16'sd0);
        drive_sample(16'sd0, 16'sh7FFF);
        drive_sample(16'sd0, 16'sh8000);
        drive_sample(16'sh7FFF, 16'sh7FFF);
        drive_sample(16'sh8000, 16'sh8000);
        drive_sample(16'sh8000, 16'sh7FFF);
        drive_sample(16'sh7FFF, 16'sh8000);
        drive_sample(-16'sd1, 16'sd0);
        drive_sample(-16'sd1, 16'sd1);
        drive_sample(-16'sd1, -16'sd1);
        drive_sample(16'sd1, 16'sd0);
        drive_sample(16'sd0, 16'sd1);
        drive_sample(16'sd0, -16'sd1);
        drive_sample(16'sd1, -16'sd1);
        drive_sample(-16'sd5, 16'sd0);
        drive_sample(16'sh8001, 16'sd0);
        drive_sample(16'sh8000, -16'sd1);
        drive_sample(16'sh8000, 16'sd1);
        drive_sample(-16'sd1, 16'sh8000);
        drive_sample(16'sh5555, 16'shAAAA);
        drive_sample(16'shAAAA, 16'sh5555);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0, 1, 2:
                begin
                    sx = SAMPLE_W'($urandom);
                    sy = SAMPLE_W'($urandom);
                end
                3:
                begin
                    sx = SAMPLE_W'(int'($urandom_range(0, 32)) - 16);
                    sy = SAMPLE_W'(int'($urandom_range(0, 32)) - 16);
                end
                4:
                begin
                    // negative X axis, where the residual may cross the wrap
                    sx = SAMPLE_W'(-1 - int'($urandom_range(0, 32767)));
                    sy = SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
                end
                5:
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        sx = SAMPLE_W'($urandom);
                        sy = SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
                    end
                    else
                    begin
                        sx = SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
                        sy = SAMPLE_W'($urandom);
                    end
                end
                6:
                begin
                    sx = corner_sample();
                    sy = corner_sample();
                end
                default:
                begin
                    sx = SAMPLE_W'($urandom);
                    sy = ($urandom_range(0, 1) == 1) ? sx : -sx;
                end
            endcase
            drive_sample(sx, sy);
        end

        start <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);

        if (mismatches == 0)
            $display("heading_from_magnetometer_xy_unit regression: pass");
        else
            $display("heading_from_magnetometer_xy_unit regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/hfm_pkg.sv
rtl/hfm_ctrl.sv
rtl/hfm_dp.sv
rtl/heading_from_magnetometer_xy_unit.sv
tb/heading_checker.sv
tb/testbench.sv
